@@ hdl/e2r_pkg.sv @@
// Shared types, constants and arithmetic helpers for the Euler angle to
// rotation matrix block. Depends on nothing; every other file imports it.
package e2r_pkg;

    // CORDIC length and derived widths
    localparam int CORDIC_STAGES = 16;
    localparam int STG_W         = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
    localparam int PIPE_LEN      = CORDIC_STAGES + 5;

    // Angle constants, degrees times 128
    localparam logic signed [16:0] TURN_UNITS         = 17'sd46080;
    localparam logic signed [16:0] HALF_TURN_UNITS    = 17'sd23040;
    localparam logic signed [16:0] QUARTER_TURN_UNITS = 17'sd11520;

    // CORDIC start vector, gain-compensated, Q.30
    localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

    // Lane order inside each cell
    localparam int LN_YAW   = 0;
    localparam int LN_PITCH = 1;
    localparam int LN_ROLL  = 2;
    localparam int LANES    = 3;

    typedef struct packed {
        logic signed [15:0] yaw_deg;
        logic signed [15:0] pitch_deg;
        logic signed [15:0] roll_deg;
    } t_in;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_out;

    // One angle in flight through the CORDIC chain
    typedef struct packed {
        logic               neg;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_lane;

    // Arctangent of 2^-i in degrees times 2^23
    function automatic logic signed [31:0] atan_q23(input logic [4:0] idx);
        logic signed [31:0] v;
        unique case (idx)
            5'd0:    v = 32'sd377487360;
            5'd1:    v = 32'sd222843801;
            5'd2:    v = 32'sd117744544;
            5'd3:    v = 32'sd59768969;
            5'd4:    v = 32'sd30000467;
            5'd5:    v = 32'sd15014858;
            5'd6:    v = 32'sd7509261;
            5'd7:    v = 32'sd3754860;
            5'd8:    v = 32'sd1877458;
            5'd9:    v = 32'sd938733;
            5'd10:   v = 32'sd469367;
            5'd11:   v = 32'sd234683;
            5'd12:   v = 32'sd117342;
            5'd13:   v = 32'sd58671;
            5'd14:   v = 32'sd29336;
            5'd15:   v = 32'sd14668;
            5'd16:   v = 32'sd7334;
            5'd17:   v = 32'sd3667;
            5'd18:   v = 32'sd1833;
            5'd19:   v = 32'sd917;
            5'd20:   v = 32'sd458;
            5'd21:   v = 32'sd229;
            5'd22:   v = 32'sd115;
            5'd23:   v = 32'sd57;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Q.30 product, rounded half up
    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        p = p + (64'sd1 <<< 29);
        return p[61:30];
    endfunction

    // Q.30 sum to Q1.15, rounded and saturated
    function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
        logic signed [33:0] r;
        logic signed [15:0] q;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767) begin
            q = 16'sh7fff;
        end else if (r < -34'sd32768) begin
            q = 16'sh8000;
        end else begin
            q = r[15:0];
        end
        return q;
    endfunction

endpackage

@@ hdl/e2r_prep.sv @@
// Angle range reduction ahead of the CORDIC chain: one turn, then fold to
// a quarter turn. Depends on e2r_pkg.
module e2r_prep
    import e2r_pkg::*;
(
    input  logic signed [15:0] i_angle,
    output t_lane              o_lane
);

    logic signed [16:0] a_ext;
    logic signed [16:0] a_turn;
    logic signed [16:0] a_fold;
    logic               neg;

    // Reduce to one turn, then move half a turn toward zero when needed
    always_comb begin
        a_ext = 17'(i_angle);
        if (a_ext >= HALF_TURN_UNITS) begin
            a_turn = a_ext - TURN_UNITS;
        end else if (a_ext < -HALF_TURN_UNITS) begin
            a_turn = a_ext + TURN_UNITS;
        end else begin
            a_turn = a_ext;
        end

        if (a_turn > QUARTER_TURN_UNITS) begin
            a_fold = a_turn - HALF_TURN_UNITS;
            neg    = 1'b1;
        end else if (a_turn < -QUARTER_TURN_UNITS) begin
            a_fold = a_turn + HALF_TURN_UNITS;
            neg    = 1'b1;
        end else begin
            a_fold = a_turn;
            neg    = 1'b0;
        end

        o_lane.neg = neg;
        o_lane.x   = CORDIC_X0;
        o_lane.y   = 32'sd0;
        o_lane.z   = 32'(a_fold) <<< 16;
    end

endmodule

@@ hdl/e2r_cell.sv @@
// One CORDIC micro-rotation for all three angles, registered.
// Depends on e2r_pkg for the lane type and the arctangent table.
module e2r_cell
    import e2r_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [STG_W-1:0] i_stage,
    input  t_lane            i_lane [LANES],
    output t_lane            o_lane [LANES]
);

    t_lane              n_lane [LANES];
    t_lane              r_lane [LANES];
    logic signed [31:0] atan_v;
    logic signed [31:0] dx;
    logic signed [31:0] dy;

    // Rotate toward zero residual angle
    always_comb begin
        atan_v = atan_q23(5'(i_stage));
        dx     = '0;
        dy     = '0;
        for (int l = 0; l < LANES; l++) begin
            dx           = i_lane[l].y >>> i_stage;
            dy           = i_lane[l].x >>> i_stage;
            n_lane[l].neg = i_lane[l].neg;
            if (!i_lane[l].z[31]) begin
                n_lane[l].x = i_lane[l].x - dx;
                n_lane[l].y = i_lane[l].y + dy;
                n_lane[l].z = i_lane[l].z - atan_v;
            end else begin
                n_lane[l].x = i_lane[l].x + dx;
                n_lane[l].y = i_lane[l].y - dy;
                n_lane[l].z = i_lane[l].z + atan_v;
            end
        end
    end

    // Hand on to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

@@ hdl/euler_to_rotation_matrix.sv @@
// Top level: ZYX direction cosine matrix from yaw, pitch and roll.
// Depends on e2r_pkg, e2r_prep and e2r_cell.
//
//   channel  | signals                        | moves
//   ---------+--------------------------------+------------------------------
//   input    | i_valid, o_stall, i_data       | yaw, pitch, roll (deg * 128)
//   output   | o_valid, i_stall, o_data       | nine Q1.15 matrix entries
//
// One transfer in per cycle while o_stall is low. The pipeline holds one
// range-reduction register, one CORDIC cell per stage, a sign stage, two
// multiplier stages and the output register.
// Each stage advances when it is empty or its successor advances, so
// bubbles collapse and input keeps flowing while a result waits, until
// every stage holds a transfer.
// Reset (synchronous, active low) clears only the stage valid bits.
module euler_to_rotation_matrix
    import e2r_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam int ST_POST = CORDIC_STAGES + 1;
    localparam int ST_M1   = CORDIC_STAGES + 2;
    localparam int ST_M2   = CORDIC_STAGES + 3;
    localparam int ST_OUT  = CORDIC_STAGES + 4;

    logic [PIPE_LEN-1:0] r_vld;
    logic [PIPE_LEN-1:0] en;

    t_lane w_prep  [LANES];
    t_lane r_pre   [LANES];
    t_lane w_chain [CORDIC_STAGES+1][LANES];

    logic signed [31:0] r_s [LANES];
    logic signed [31:0] r_c [LANES];

    // first product stage
    logic signed [31:0] r1_spcy, r1_spsy, r1_cpcy, r1_cpsy, r1_cpsr, r1_cpcr;
    logic signed [31:0] r1_crsy, r1_srsy, r1_crcy, r1_srcy, r1_sp, r1_sr, r1_cr;
    // second product stage
    logic signed [31:0] r2_a, r2_b, r2_c, r2_d;
    logic signed [31:0] r2_crsy, r2_srsy, r2_crcy, r2_srcy;
    logic signed [31:0] r2_cpcy, r2_cpsy, r2_cpsr, r2_cpcr, r2_sp;

    t_out r_out;

    // Advance enables, from the output back to the input
    always_comb begin
        en[PIPE_LEN-1] = !r_vld[PIPE_LEN-1] || !i_stall;
        for (int k = PIPE_LEN - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < PIPE_LEN; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Range reduction
    e2r_prep u_prep_yaw   (.i_angle(i_data.yaw_deg),   .o_lane(w_prep[LN_YAW]));
    e2r_prep u_prep_pitch (.i_angle(i_data.pitch_deg), .o_lane(w_prep[LN_PITCH]));
    e2r_prep u_prep_roll  (.i_angle(i_data.roll_deg),  .o_lane(w_prep[LN_ROLL]));

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_pre <= w_prep;
        end
    end

    assign w_chain[0] = r_pre;

    // CORDIC chain
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        e2r_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (en[g+1]),
            .i_stage (STG_W'(g)),
            .i_lane  (w_chain[g]),
            .o_lane  (w_chain[g+1])
        );
    end

    // Undo the half-turn fold
    always_ff @(posedge i_clk) begin
        if (en[ST_POST]) begin
            for (int l = 0; l < LANES; l++) begin
                r_s[l] <= w_chain[CORDIC_STAGES][l].neg ? -w_chain[CORDIC_STAGES][l].y
                                                        :  w_chain[CORDIC_STAGES][l].y;
                r_c[l] <= w_chain[CORDIC_STAGES][l].neg ? -w_chain[CORDIC_STAGES][l].x
                                                        :  w_chain[CORDIC_STAGES][l].x;
            end
        end
    end

    // First products
    always_ff @(posedge i_clk) begin
        if (en[ST_M1]) begin
            r1_spcy <= mul_q30(r_s[LN_PITCH], r_c[LN_YAW]);
            r1_spsy <= mul_q30(r_s[LN_PITCH], r_s[LN_YAW]);
            r1_cpcy <= mul_q30(r_c[LN_PITCH], r_c[LN_YAW]);
            r1_cpsy <= mul_q30(r_c[LN_PITCH], r_s[LN_YAW]);
            r1_cpsr <= mul_q30(r_c[LN_PITCH], r_s[LN_ROLL]);
            r1_cpcr <= mul_q30(r_c[LN_PITCH], r_c[LN_ROLL]);
            r1_crsy <= mul_q30(r_c[LN_ROLL], r_s[LN_YAW]);
            r1_srsy <= mul_q30(r_s[LN_ROLL], r_s[LN_YAW]);
            r1_crcy <= mul_q30(r_c[LN_ROLL], r_c[LN_YAW]);
            r1_srcy <= mul_q30(r_s[LN_ROLL], r_c[LN_YAW]);
            r1_sp   <= r_s[LN_PITCH];
            r1_sr   <= r_s[LN_ROLL];
            r1_cr   <= r_c[LN_ROLL];
        end
    end

    // Second products
    always_ff @(posedge i_clk) begin
        if (en[ST_M2]) begin
            r2_a    <= mul_q30(r1_sr, r1_spcy);
            r2_b    <= mul_q30(r1_cr, r1_spcy);
            r2_c    <= mul_q30(r1_sr, r1_spsy);
            r2_d    <= mul_q30(r1_cr, r1_spsy);
            r2_crsy <= r1_crsy;
            r2_srsy <= r1_srsy;
            r2_crcy <= r1_crcy;
            r2_srcy <= r1_srcy;
            r2_cpcy <= r1_cpcy;
            r2_cpsy <= r1_cpsy;
            r2_cpsr <= r1_cpsr;
            r2_cpcr <= r1_cpcr;
            r2_sp   <= r1_sp;
        end
    end

    // Sum, round and saturate into the output register
    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_out.m00 <= to_q15(34'(r2_cpcy));
            r_out.m01 <= to_q15(34'(r2_a) - 34'(r2_crsy));
            r_out.m02 <= to_q15(34'(r2_b) + 34'(r2_srsy));
            r_out.m10 <= to_q15(34'(r2_cpsy));
            r_out.m11 <= to_q15(34'(r2_c) + 34'(r2_crcy));
            r_out.m12 <= to_q15(34'(r2_d) - 34'(r2_srcy));
            r_out.m20 <= to_q15(-34'(r2_sp));
            r_out.m21 <= to_q15(34'(r2_cpsr));
            r_out.m22 <= to_q15(34'(r2_cpcr));
        end
    end

    assign o_valid = r_vld[PIPE_LEN-1];
    assign o_data  = r_out;

endmodule
